// ===== rtl/abb_pkg.sv =====
// package: shared constants, types and angle tables for the arc bounding box
`timescale 1ns / 1ps
package abb_pkg;

    localparam int COORD_FRAC_BITS_DEF = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 28;
    localparam int CORDIC_STAGES_DEF   = 24;

    localparam int ANG_EXTRA = 30;
    // internal angle width: 32 input bits plus the extra fraction bits, plus headroom
    localparam int AW = 64;
    // cordic datapath width, q1.30 plus growth and sign
    localparam int XW = 34;

    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam logic signed [XW-1:0] GAIN_Q30 = XW'(652032874);

    // m * pi/2 in the internal angle format (angle_frac + 30 fraction bits)
    function automatic logic signed [AW-1:0] half_pi_mult(input int unsigned m,
                                                          input int unsigned afb);
        logic [127:0] v;
        int unsigned  sh;
        sh = 31 - afb;
        v  = 128'(m) * 128'(PI_Q60);
        v  = (v + (128'(1) << (sh - 1))) >> sh;
        return AW'(v);
    endfunction

    // atan(2^-i) in the internal angle format, taylor series at 60 bits
    function automatic logic signed [AW-1:0] atan_pow2(input int unsigned i,
                                                       input int unsigned afb);
        logic [63:0]  acc;
        logic [63:0]  term;
        int unsigned  sh;
        int unsigned  e;
        sh  = 30 - afb;
        acc = '0;
        if (i == 0) begin
            acc = PI_Q60 >> 2;
        end
        else begin
            for (int k = 0; k < 64; k++) begin
                e = i * (2 * k + 1);
                if (e <= 60) begin
                    term = (64'(1) << (60 - e)) / 64'(2 * k + 1);
                    if (k % 2 == 1)
                        acc = acc - term;
                    else
                        acc = acc + term;
                end
            end
        end
        return AW'((acc + (64'(1) << (sh - 1))) >> sh);
    endfunction

    // one cordic rotation lane
    typedef struct packed {
        logic signed [AW-1:0] r;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic                 neg;
    } rot_t;

    // item context that rides alongside the cordic lanes
    typedef struct packed {
        logic                 is_line;
        logic signed [31:0]   cx;
        logic signed [31:0]   cy;
        logic [30:0]          rad;
        logic [3:0]           xing;
        logic signed [31:0]   ex;
        logic signed [31:0]   ey;
    } ctx_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -66'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

endpackage

// ===== rtl/abb_reduce.sv =====
// angle reduction into [-pi/2, pi/2], pipelined through the divider, wrap and fold registers
`timescale 1ns / 1ps
module abb_reduce #(
    parameter int ANGLE_FRAC_BITS = abb_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic signed [31:0]              angle,
    output abb_pkg::rot_t                   rot
);
    localparam logic signed [abb_pkg::AW-1:0] TW =
        abb_pkg::half_pi_mult(4, ANGLE_FRAC_BITS);
    localparam logic signed [abb_pkg::AW-1:0] PI =
        abb_pkg::half_pi_mult(2, ANGLE_FRAC_BITS);
    localparam logic signed [abb_pkg::AW-1:0] HP =
        abb_pkg::half_pi_mult(1, ANGLE_FRAC_BITS);
    // |angle| <= 2^31 * 2^30 and 2pi > 6 * 2^(afb+30): the quotient stays under 2^(31-afb)
    // remainder found one quotient bit a stage, restoring, on the magnitude
    localparam int QB = 32 - ANGLE_FRAC_BITS;

    logic                            sgn_reg    [QB+1];
    logic        [abb_pkg::AW-1:0]   mag_reg    [QB+1];
    logic        [abb_pkg::AW-1:0]   mag_next   [QB+1];
    logic signed [abb_pkg::AW-1:0]   r_reg;
    logic signed [abb_pkg::AW-1:0]   r_next;
    abb_pkg::rot_t                   rot_reg;
    abb_pkg::rot_t                   rot_next;

    always_comb
    begin
        logic signed [abb_pkg::AW-1:0] a;
        a = abb_pkg::AW'(angle) <<< abb_pkg::ANG_EXTRA;
        mag_next[0] = (a < 0) ? abb_pkg::AW'(-a) : abb_pkg::AW'(a);
        for (int s = 1; s <= QB; s++) begin
            logic [abb_pkg::AW-1:0] d;
            d = abb_pkg::AW'(TW) << (QB - s);
            mag_next[s] = (mag_reg[s-1] >= d) ? mag_reg[s-1] - d : mag_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        sgn_reg[0] <= angle[31];
        mag_reg[0] <= mag_next[0];
        for (int s = 1; s <= QB; s++) begin
            sgn_reg[s] <= sgn_reg[s-1];
            mag_reg[s] <= mag_next[s];
        end
        r_reg   <= r_next;
        rot_reg <= rot_next;
    end

    // c remainder takes the sign of the dividend, then wrap and fold
    always_comb
    begin
        logic signed [abb_pkg::AW-1:0] r;
        r = sgn_reg[QB] ? -$signed(mag_reg[QB]) : $signed(mag_reg[QB]);
        if (r > PI)
            r = r - TW;
        if (r < -PI)
            r = r + TW;
        r_next = r;
    end

    always_comb
    begin
        rot_next.neg = 1'b0;
        rot_next.r   = r_reg;
        if (r_reg > HP) begin
            rot_next.r   = r_reg - PI;
            rot_next.neg = 1'b1;
        end
        else if (r_reg < -HP) begin
            rot_next.r   = r_reg + PI;
            rot_next.neg = 1'b1;
        end
        rot_next.x = abb_pkg::GAIN_Q30;
        rot_next.y = '0;
    end

    assign rot = rot_reg;

endmodule

// ===== rtl/abb_cordic_cell.sv =====
// one cordic micro-rotation cell, registered, applied to both the begin and the end lane
`timescale 1ns / 1ps
module abb_cordic_cell #(
    parameter int ANGLE_FRAC_BITS = abb_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int IDX             = 0
) (
    input  logic          clk,
    input  abb_pkg::rot_t b_in,
    input  abb_pkg::rot_t e_in,
    output abb_pkg::rot_t b_out,
    output abb_pkg::rot_t e_out
);
    localparam logic signed [abb_pkg::AW-1:0] AT =
        abb_pkg::atan_pow2(IDX, ANGLE_FRAC_BITS);

    function automatic abb_pkg::rot_t step(input abb_pkg::rot_t v);
        abb_pkg::rot_t o;
        o = v;
        if (v.r >= 0) begin
            o.x = v.x - (v.y >>> IDX);
            o.y = v.y + (v.x >>> IDX);
            o.r = v.r - AT;
        end
        else begin
            o.x = v.x + (v.y >>> IDX);
            o.y = v.y - (v.x >>> IDX);
            o.r = v.r + AT;
        end
        return o;
    endfunction

    abb_pkg::rot_t b_reg;
    abb_pkg::rot_t e_reg;

    always_ff @(posedge clk)
    begin
        b_reg <= step(b_in);
        e_reg <= step(e_in);
    end

    assign b_out = b_reg;
    assign e_out = e_reg;

endmodule

// ===== rtl/abb_box.sv =====
// endpoint scaling and bounding-box merge, pipelined
`timescale 1ns / 1ps
module abb_box (
    input  logic                clk,
    input  abb_pkg::rot_t       b_rot,
    input  abb_pkg::rot_t       e_rot,
    input  abb_pkg::ctx_t       ctx,
    output logic signed [31:0]  min_x,
    output logic signed [31:0]  max_x,
    output logic signed [31:0]  min_y,
    output logic signed [31:0]  max_y
);
    logic signed [65:0] prod_next [4];
    logic signed [65:0] prod_reg  [4];
    abb_pkg::ctx_t      ctx_reg;
    logic signed [31:0] pt_next [4];
    logic signed [31:0] pt_reg  [4];
    abb_pkg::ctx_t      ctx2_reg;
    logic signed [31:0] lox_reg, hix_reg, loy_reg, hiy_reg;

    always_comb
    begin
        logic signed [abb_pkg::XW-1:0] f [4];
        f[0] = b_rot.neg ? -b_rot.x : b_rot.x;
        f[1] = b_rot.neg ? -b_rot.y : b_rot.y;
        f[2] = e_rot.neg ? -e_rot.x : e_rot.x;
        f[3] = e_rot.neg ? -e_rot.y : e_rot.y;
        for (int k = 0; k < 4; k++)
            prod_next[k] = $signed({1'b0, ctx.rad}) * f[k];
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++) begin
            logic signed [65:0] sc;
            logic signed [31:0] c;
            sc = (prod_reg[k] + 66'sd536870912) >>> 30;
            c  = (k % 2 == 0) ? ctx_reg.cx : ctx_reg.cy;
            pt_next[k] = abb_pkg::sat32(66'(c) + sc);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        ctx_reg  <= ctx;
        pt_reg   <= pt_next;
        ctx2_reg <= ctx_reg;
    end

    always_ff @(posedge clk)
    begin
        logic signed [31:0] lx, hx, ly, hy, v;
        if (ctx2_reg.is_line) begin
            lx = (ctx2_reg.cx < ctx2_reg.ex) ? ctx2_reg.cx : ctx2_reg.ex;
            hx = (ctx2_reg.cx < ctx2_reg.ex) ? ctx2_reg.ex : ctx2_reg.cx;
            ly = (ctx2_reg.cy < ctx2_reg.ey) ? ctx2_reg.cy : ctx2_reg.ey;
            hy = (ctx2_reg.cy < ctx2_reg.ey) ? ctx2_reg.ey : ctx2_reg.cy;
        end
        else begin
            lx = (pt_reg[2] < pt_reg[0]) ? pt_reg[2] : pt_reg[0];
            hx = (pt_reg[2] > pt_reg[0]) ? pt_reg[2] : pt_reg[0];
            ly = (pt_reg[3] < pt_reg[1]) ? pt_reg[3] : pt_reg[1];
            hy = (pt_reg[3] > pt_reg[1]) ? pt_reg[3] : pt_reg[1];
            v = abb_pkg::sat32(66'(ctx2_reg.cy) + 66'(ctx2_reg.rad));
            if (ctx2_reg.xing[0] && v > hy) hy = v;
            v = abb_pkg::sat32(66'(ctx2_reg.cx) - 66'(ctx2_reg.rad));
            if (ctx2_reg.xing[1] && v < lx) lx = v;
            v = abb_pkg::sat32(66'(ctx2_reg.cy) - 66'(ctx2_reg.rad));
            if (ctx2_reg.xing[2] && v < ly) ly = v;
            v = abb_pkg::sat32(66'(ctx2_reg.cx) + 66'(ctx2_reg.rad));
            if (ctx2_reg.xing[3] && v > hx) hx = v;
        end
        lox_reg <= lx;
        hix_reg <= hx;
        loy_reg <= ly;
        hiy_reg <= hy;
    end

    assign min_x = lox_reg;
    assign max_x = hix_reg;
    assign min_y = loy_reg;
    assign max_y = hiy_reg;

endmodule

// ===== rtl/arc_bounding_box.sv =====
// top level: bounding box of a circular arc or a line segment
`timescale 1ns / 1ps
// usage
//   command channel: a transaction is taken at each rising edge with start high;
//   busy is tied low, so a new item may enter in every cycle
//   result channel: done pulses for one cycle with min_x, max_x, min_y, max_y;
//   the receiver cannot stall, results leave in input order
//   path: angle reduction (magnitude divider stages, wrap and fold registers),
//   then a row of CORDIC_STAGES rotation cells, then the product, point and merge
//   registers of the box
//   throughput: one transaction per cycle, set by the fully pipelined cell row
//   lines take the same path so order is kept; radius and angles are ignored
//   for lines, segment ends are ignored for arcs
//   reset clears only the valid pipeline, no results are emitted after reset
//   until new transactions arrive
module arc_bounding_box #(
    parameter int COORD_FRAC_BITS = abb_pkg::COORD_FRAC_BITS_DEF,
    parameter int ANGLE_FRAC_BITS = abb_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES   = abb_pkg::CORDIC_STAGES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               is_line,
    input  logic signed [31:0] center_x,
    input  logic signed [31:0] center_y,
    input  logic [30:0]        radius,
    input  logic signed [31:0] begin_angle,
    input  logic signed [31:0] end_angle,
    input  logic signed [31:0] seg_end_x,
    input  logic signed [31:0] seg_end_y,
    output logic               done,
    output logic signed [31:0] min_x,
    output logic signed [31:0] max_x,
    output logic signed [31:0] min_y,
    output logic signed [31:0] max_y
);
    // coordinates share one binary point, so the math does not depend on it
    localparam int RED_LAT = 32 - ANGLE_FRAC_BITS + 3;
    localparam int LAT     = RED_LAT + CORDIC_STAGES + 3;
    localparam int CTX_LAT = RED_LAT + CORDIC_STAGES;
    localparam logic signed [abb_pkg::AW-1:0] Q1 =
        abb_pkg::half_pi_mult(1, ANGLE_FRAC_BITS);
    localparam logic signed [abb_pkg::AW-1:0] Q2 =
        abb_pkg::half_pi_mult(2, ANGLE_FRAC_BITS);
    localparam logic signed [abb_pkg::AW-1:0] Q3 =
        abb_pkg::half_pi_mult(3, ANGLE_FRAC_BITS);
    localparam logic signed [abb_pkg::AW-1:0] Q4 =
        abb_pkg::half_pi_mult(4, ANGLE_FRAC_BITS);
    localparam logic [COORD_FRAC_BITS-1:0] UNUSED_FRAC = '0;

    logic [LAT-1:0]  vld_reg;
    abb_pkg::ctx_t   ctx_in;
    abb_pkg::ctx_t   ctx_reg [CTX_LAT];
    abb_pkg::rot_t   b_chain [CORDIC_STAGES+1];
    abb_pkg::rot_t   e_chain [CORDIC_STAGES+1];

    assign busy = |UNUSED_FRAC;

    // arc crossings of the axis extremes, from the angles shifted up by 2pi when begin is negative
    always_comb
    begin
        logic signed [abb_pkg::AW-1:0] bs, es;
        bs = abb_pkg::AW'(begin_angle) <<< abb_pkg::ANG_EXTRA;
        es = abb_pkg::AW'(end_angle) <<< abb_pkg::ANG_EXTRA;
        if (begin_angle < 0) begin
            bs = bs + Q4;
            es = es + Q4;
        end
        ctx_in.is_line = is_line;
        ctx_in.cx      = center_x;
        ctx_in.cy      = center_y;
        ctx_in.rad     = radius;
        ctx_in.ex      = seg_end_x;
        ctx_in.ey      = seg_end_y;
        ctx_in.xing[0] = (bs < Q1) && (es > Q1);
        ctx_in.xing[1] = (bs < Q2) && (es > Q2);
        ctx_in.xing[2] = (bs < Q3) && (es > Q3);
        ctx_in.xing[3] = (bs < Q4) && (es > Q4);
    end

    always_ff @(posedge clk)
    begin
        ctx_reg[0] <= ctx_in;
        for (int s = 1; s < CTX_LAT; s++)
            ctx_reg[s] <= ctx_reg[s-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LAT-2:0], start & ~busy};
    end

    abb_reduce #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_red_b (
        .clk(clk), .angle(begin_angle), .rot(b_chain[0])
    );
    abb_reduce #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_red_e (
        .clk(clk), .angle(end_angle), .rot(e_chain[0])
    );

    // row of rotation cells, one micro-rotation each
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        abb_cordic_cell #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .IDX(g)) u_cell (
            .clk(clk),
            .b_in(b_chain[g]), .e_in(e_chain[g]),
            .b_out(b_chain[g+1]), .e_out(e_chain[g+1])
        );
    end

    abb_box u_box (
        .clk(clk),
        .b_rot(b_chain[CORDIC_STAGES]),
        .e_rot(e_chain[CORDIC_STAGES]),
        .ctx(ctx_reg[CTX_LAT-1]),
        .min_x(min_x), .max_x(max_x), .min_y(min_y), .max_y(max_y)
    );

    assign done = vld_reg[LAT-1];

endmodule

// ===== rtl/abb_checker.sv =====
// checker on the top-level ports, bound to the top level
`timescale 1ns / 1ps
module abb_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [31:0] min_x,
    input logic signed [31:0] max_x,
    input logic signed [31:0] min_y,
    input logic signed [31:0] max_y
);
    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");
    a_order_x: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (min_x <= max_x)) else $error("x box inverted");
    a_order_y: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (min_y <= max_y)) else $error("y box inverted");
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 34) || !$past(rst_n, 34))
        else $error("result without transaction");
endmodule

bind arc_bounding_box abb_checker u_abb_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .min_x(min_x), .max_x(max_x), .min_y(min_y), .max_y(max_y)
);

// ===== bench/arc_bounding_box_tb.sv =====
// testbench: arc and segment bounding box checked against typed boxes and a bit-exact cordic predictor
`timescale 1ns / 1ps
module arc_bounding_box_tb;

    localparam int  ANG_FB      = abb_pkg::ANGLE_FRAC_BITS_DEF;
    localparam int  ROT_STAGES  = abb_pkg::CORDIC_STAGES_DEF;
    localparam int  DRAIN_WAIT  = 60;       // extra wait after the last expected result, to catch stray results
    localparam int  CYCLE_LIMIT = 400000;   // many times the slowest correct run
    localparam int  RAND_ITEMS  = 550;
    localparam logic [63:0] PI_60 = 64'h3243F6A8885A308D;
    localparam longint      K_GAIN = 652032874;

    // q3.28 angle literals used by the directed rows and the random shapes
    localparam int A_HALF_PI = 421657428;
    localparam int A_PI      = 843314857;
    localparam int A_TWO_PI  = 1686629713;
    localparam int I_MAX     = 32'sh7FFFFFFF;
    localparam int I_MIN     = 32'sh80000000;

    typedef struct {
        logic               is_line;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic [30:0]        rad;
        logic signed [31:0] ba;
        logic signed [31:0] ea;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
    } shape_t;

    typedef struct {
        logic signed [31:0] lox;
        logic signed [31:0] hix;
        logic signed [31:0] loy;
        logic signed [31:0] hiy;
    } box_t;

    typedef struct {
        shape_t s;
        bit     typed;   // expected box given in the row
        box_t   b;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               is_line;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic [30:0]        radius;
    logic signed [31:0] begin_angle;
    logic signed [31:0] end_angle;
    logic signed [31:0] seg_end_x;
    logic signed [31:0] seg_end_y;
    logic               done;
    logic signed [31:0] min_x;
    logic signed [31:0] max_x;
    logic signed [31:0] min_y;
    logic signed [31:0] max_y;

    box_t   pending_boxes[$];
    int     mismatches = 0;
    int     cycles = 0;

    arc_bounding_box dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .is_line    (is_line),
        .center_x   (center_x),
        .center_y   (center_y),
        .radius     (radius),
        .begin_angle(begin_angle),
        .end_angle  (end_angle),
        .seg_end_x  (seg_end_x),
        .seg_end_y  (seg_end_y),
        .done       (done),
        .min_x      (min_x),
        .max_x      (max_x),
        .min_y      (min_y),
        .max_y      (max_y)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // predictor: fixed-point angle constants and cordic
    // ---------------------------------------------------------------

    // m quarter turns in the widened angle format, rounded to nearest
    function automatic longint quarter_turns(input int unsigned m);
        logic [63:0] v;
        int unsigned sh;
        sh = 31 - ANG_FB;
        v  = 64'(m) * PI_60;
        v  = (v + (64'd1 << (sh - 1))) >> sh;
        return longint'(v);
    endfunction

    // arctangent of 2^-i from the odd power series at 60 fraction bits
    function automatic longint arctan_step(input int unsigned i);
        logic [63:0] acc;
        int unsigned sh;
        int unsigned e;
        sh  = 30 - ANG_FB;
        acc = '0;
        if (i == 0)
            acc = PI_60 >> 2;
        else
        begin
            for (int k = 0; k < 64; k++)
            begin
                e = i * (2 * k + 1);
                if (e <= 60)
                begin
                    if (k % 2 == 1)
                        acc = acc - ((64'd1 << (60 - e)) / 64'(2 * k + 1));
                    else
                        acc = acc + ((64'd1 << (60 - e)) / 64'(2 * k + 1));
                end
            end
        end
        return longint'((acc + (64'd1 << (sh - 1))) >> sh);
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // rounds radius times a q1.30 factor back to q16.16
    function automatic longint radial(input longint rad, input longint f);
        return (rad * f + (64'sd1 << 29)) >>> 30;
    endfunction

    // cosine and sine in q1.30 of a widened angle
    task automatic rotate(input longint a, output longint c, output longint s);
        longint full;
        longint half;
        longint quart;
        longint r;
        longint x;
        longint y;
        longint t;
        bit     flip;
        full  = quarter_turns(4);
        half  = quarter_turns(2);
        quart = quarter_turns(1);
        r     = a % full;
        x     = K_GAIN;
        y     = 0;
        flip  = 1'b0;
        if (r > half)
            r -= full;
        if (r < -half)
            r += full;
        // fold into the right half plane, negating the result
        if (r > quart)
        begin
            r -= half;
            flip = 1'b1;
        end
        else if (r < -quart)
        begin
            r += half;
            flip = 1'b1;
        end
        for (int i = 0; i < ROT_STAGES; i++)
        begin
            if (r >= 0)
            begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                x = t;
                r -= arctan_step(i);
            end
            else
            begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                x = t;
                r += arctan_step(i);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic predict_box(input shape_t sh, output box_t bx);
        longint cx;
        longint cy;
        longint rad;
        longint b;
        longint e;
        longint bs;
        longint es;
        longint c;
        longint s;
        longint v;
        longint lox;
        longint hix;
        longint loy;
        longint hiy;
        cx = longint'(sh.cx);
        cy = longint'(sh.cy);
        if (sh.is_line)
        begin
            longint ex;
            longint ey;
            ex  = longint'(sh.ex);
            ey  = longint'(sh.ey);
            lox = (cx < ex) ? cx : ex;
            hix = (cx < ex) ? ex : cx;
            loy = (cy < ey) ? cy : ey;
            hiy = (cy < ey) ? ey : cy;
        end
        else
        begin
            rad = longint'({33'd0, sh.rad});
            b   = longint'(sh.ba) * (64'sd1 << 30);
            e   = longint'(sh.ea) * (64'sd1 << 30);
            bs  = b;
            es  = e;
            // negative begin shifts both angles up a full turn for the crossing test
            if (b < 0)
            begin
                bs = b + quarter_turns(4);
                es = e + quarter_turns(4);
            end
            rotate(b, c, s);
            lox = clamp32(cx + radial(rad, c));
            hix = lox;
            loy = clamp32(cy + radial(rad, s));
            hiy = loy;
            rotate(e, c, s);
            v = clamp32(cx + radial(rad, c));
            if (v < lox) lox = v;
            if (v > hix) hix = v;
            v = clamp32(cy + radial(rad, s));
            if (v < loy) loy = v;
            if (v > hiy) hiy = v;
            // axis extremes strictly inside the sweep
            if (bs < quarter_turns(1) && es > quarter_turns(1))
            begin
                v = clamp32(cy + rad);
                if (v > hiy) hiy = v;
            end
            if (bs < quarter_turns(2) && es > quarter_turns(2))
            begin
                v = clamp32(cx - rad);
                if (v < lox) lox = v;
            end
            if (bs < quarter_turns(3) && es > quarter_turns(3))
            begin
                v = clamp32(cy - rad);
                if (v < loy) loy = v;
            end
            if (bs < quarter_turns(4) && es > quarter_turns(4))
            begin
                v = clamp32(cx + rad);
                if (v > hix) hix = v;
            end
        end
        bx.lox = lox[31:0];
        bx.hix = hix[31:0];
        bx.loy = loy[31:0];
        bx.hiy = hiy[31:0];
    endtask

    // ---------------------------------------------------------------
    // driver: one transaction, taken at the rising edge with busy low
    // ---------------------------------------------------------------
    task automatic send_shape(input shape_t sh, input bit typed, input box_t given);
        box_t bx;
        @(negedge clk);
        start       = 1'b1;
        is_line     = sh.is_line;
        center_x    = sh.cx;
        center_y    = sh.cy;
        radius      = sh.rad;
        begin_angle = sh.ba;
        end_angle   = sh.ea;
        seg_end_x   = sh.ex;
        seg_end_y   = sh.ey;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        if (typed)
            bx = given;
        else
            predict_box(sh, bx);
        pending_boxes.insert(pending_boxes.size(), bx);
    endtask

    // on some calls lowers start for a random gap, mostly short with the odd long one
    task automatic idle_gap();
        int n;
        if ($urandom_range(0, 99) < 55)
            return;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
        @(negedge clk);
        start = 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    function automatic shape_t random_shape();
        shape_t sh;
        int     pick;
        pick       = $urandom_range(0, 99);
        sh.is_line = (pick < 20);
        sh.cx      = $urandom;
        sh.cy      = $urandom;
        sh.ex      = $urandom;
        sh.ey      = $urandom;
        sh.rad     = 31'($urandom);
        sh.ba      = $urandom;
        sh.ea      = $urandom;
        if (pick >= 20 && pick < 90)
        begin
            // well-formed arcs: mostly modest sizes, mostly forward sweeps up to a little over a turn
            if ($urandom_range(0, 3) != 0)
            begin
                sh.cx = int'($urandom_range(0, 32'h01FFFFFF)) - 32'sh01000000;
                sh.cy = int'($urandom_range(0, 32'h01FFFFFF)) - 32'sh01000000;
                sh.rad = 31'($urandom_range(0, 32'h00FFFFFF));
            end
            sh.ba = int'($urandom_range(0, 2 * A_TWO_PI)) - A_TWO_PI;
            sh.ea = sh.ba + int'($urandom_range(0, A_TWO_PI + A_HALF_PI));
            if ($urandom_range(0, 9) == 0)
                sh.ea = sh.ba - int'($urandom_range(0, A_PI));
        end
        return sh;
    endfunction

    // ---------------------------------------------------------------
    // result check: done marks a one-cycle result, compared in order
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        box_t want;
        if (rst_n && done)
        begin
            if (pending_boxes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result at cycle %0d", cycles);
            end
            else
            begin
                want = pending_boxes.pop_front();
                if (min_x !== want.lox || max_x !== want.hix ||
                    min_y !== want.loy || max_y !== want.hiy)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("box mismatch cycle %0d exp %h %h %h %h got %h %h %h %h",
                                 cycles, want.lox, want.hix, want.loy, want.hiy,
                                 min_x, max_x, min_y, max_y);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // directed rows: typed boxes where the answer is obvious, predicted boxes for the rest
    row_t rows[] = '{
        // segment at the coordinate extremes, both orders
        '{'{1'b1, I_MIN, I_MAX, 31'h7FFFFFFF, I_MAX, I_MIN, I_MAX, I_MIN}, 1'b1,
          '{I_MIN, I_MAX, I_MIN, I_MAX}},
        '{'{1'b1, I_MAX, I_MIN, 31'd0, 0, 0, I_MIN, I_MAX}, 1'b1,
          '{I_MIN, I_MAX, I_MIN, I_MAX}},
        // degenerate segment
        '{'{1'b1, 32'sd5, -32'sd7, 31'd0, 0, 0, 32'sd5, -32'sd7}, 1'b1,
          '{32'sd5, 32'sd5, -32'sd7, -32'sd7}},
        // zero radius collapses to the centre
        '{'{1'b0, I_MAX, I_MIN, 31'd0, I_MIN, I_MAX, 0, 0}, 1'b1,
          '{I_MAX, I_MAX, I_MIN, I_MIN}},
        '{'{1'b0, I_MIN, I_MAX, 31'd0, 0, A_TWO_PI, I_MAX, I_MAX}, 1'b1,
          '{I_MIN, I_MIN, I_MAX, I_MAX}},
        // unit arcs: each quadrant crossing, full turn, negative begin
        '{'{1'b0, 0, 0, 31'h10000, 0, A_TWO_PI, 0, 0}, 1'b0, '{0, 0, 0, 0}},
        '{'{1'b0, 0, 0, 31'h10000, 0, A_PI, 0, 0}, 1'b0, '{0, 0, 0, 0}},
        '{'{1'b0, 0, 0, 31'h10000, A_PI, A_TWO_PI, 0, 0}, 1'b0, '{0, 0, 0, 0}},
        '{'{1'b0, 0, 0, 31'h10000, -A_HALF_PI, A_HALF_PI, 0, 0}, 1'b0, '{0, 0, 0, 0}},
        '{'{1'b0, 0, 0, 31'h10000, -A_TWO_PI, A_TWO_PI, 0, 0}, 1'b0, '{0, 0, 0, 0}},
        // arc between the half-pi and pi literals, each within rounding of a quarter turn
        '{'{1'b0, 0, 0, 31'h10000, A_HALF_PI, A_PI, 0, 0}, 1'b0, '{0, 0, 0, 0}},
        // equal and inverted angles
        '{'{1'b0, 32'sh100, 32'sh200, 31'h30000, A_HALF_PI, A_HALF_PI, 0, 0}, 1'b0,
          '{0, 0, 0, 0}},
        '{'{1'b0, 0, 0, 31'h10000, A_TWO_PI, 0, 0, 0}, 1'b0, '{0, 0, 0, 0}},
        // large angles beyond a turn, both signs
        '{'{1'b0, 0, 0, 31'h7FFFFFFF, I_MIN, I_MAX, 0, 0}, 1'b0, '{0, 0, 0, 0}},
        '{'{1'b0, 0, 0, 31'h12345, I_MAX, I_MIN, 0, 0}, 1'b0, '{0, 0, 0, 0}},
        // saturation of the centre plus radius sums
        '{'{1'b0, I_MAX, I_MAX, 31'h7FFFFFFF, 0, A_TWO_PI, 0, 0}, 1'b0, '{0, 0, 0, 0}},
        '{'{1'b0, I_MIN, I_MIN, 31'h7FFFFFFF, -A_PI, A_PI, I_MAX, I_MAX}, 1'b0,
          '{0, 0, 0, 0}}
    };

    initial
    begin
        box_t none;
        none        = '{0, 0, 0, 0};
        rst_n       = 1'b0;
        start       = 1'b0;
        is_line     = 1'b0;
        center_x    = '0;
        center_y    = '0;
        radius      = '0;
        begin_angle = '0;
        end_angle   = '0;
        seg_end_x   = '0;
        seg_end_y   = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table, back to back then with gaps
        foreach (rows[i])
        begin
            send_shape(rows[i].s, rows[i].typed, rows[i].b);
            if (i > 8)
                idle_gap();
        end

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            send_shape(random_shape(), 1'b0, none);
            // a stretch with no gaps in the middle of the run
            if (n < 200 || n > 300)
                idle_gap();
            // hold off until the pipeline has drained
            if (n == 150)
            begin
                @(negedge clk);
                start = 1'b0;
                while (pending_boxes.size() != 0)
                    @(negedge clk);
            end
        end
        @(negedge clk);
        start = 1'b0;

        while (pending_boxes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0 && pending_boxes.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
